/* src/assert_macros.svh */
// shared assertion macros, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_AT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

/* src/u2u_pkg.sv */
package u2u_pkg;

  // one result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        last;
    logic        error;
    logic [15:0] total_units;
  } result_t;

  // decoder string status
  typedef struct packed {
    logic        sticky_err;
    logic [1:0]  bytes_rem;
    logic [15:0] unit_cnt;
  } dec_status_t;

  // open sequence length codes
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // lead byte ranges
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  // continuation byte check
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // code point limits
  localparam logic [20:0] MIN_TWO   = 21'h80;
  localparam logic [20:0] MIN_THREE = 21'h800;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] SURR_LO   = 21'hD800;
  localparam logic [20:0] SURR_HI   = 21'hDFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;

  // surrogate bases
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  localparam logic [14:0] CAP_RESET = 15'h7FFF;

  // output queue entries, matching its 2-bit pointers
  localparam int OUTQ_DEPTH = 4;

endpackage

/* src/u2u_in_if.sv */
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink (input valid, in_byte, end_of_string, output ready);
endinterface

/* src/u2u_out_if.sv */
interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        last;
  logic        error;
  logic [15:0] total_units;

  modport source (output valid, code_unit, unit_valid, last, error, total_units,
                  input ready);
  modport sink (input valid, code_unit, unit_valid, last, error, total_units,
                output ready);
endinterface

/* src/u2u_cfg_if.sv */
interface u2u_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] capacity_units;

  modport source (output valid, capacity_units, input ready);
  modport sink (input valid, capacity_units, output ready);
endinterface

/* src/u2u_decode.sv */
module u2u_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 eos_i,
  input  logic [14:0]          capacity_i,
  output logic [1:0]           num_o,
  output u2u_pkg::result_t     r0_o,
  output u2u_pkg::result_t     r1_o,
  output u2u_pkg::dec_status_t status_o
);

  logic [20:0] pv_q, pv_d;
  logic [1:0]  br_q, br_d;
  logic [1:0]  sl_q, sl_d;
  logic        err_q, err_d;
  logic [15:0] cnt_q, cnt_d;

  // per-byte decode, value check and unit emission
  always_comb begin
    logic        done;
    logic        raise;
    logic        need2;
    logic [20:0] cp;
    logic [20:0] minimum;
    logic [20:0] pv_shift;
    logic [20:0] v;
    logic [16:0] sum;

    pv_d     = pv_q;
    br_d     = br_q;
    sl_d     = sl_q;
    err_d    = err_q;
    cnt_d    = cnt_q;
    done     = 1'b0;
    raise    = 1'b0;
    cp       = '0;
    minimum  = '0;
    pv_shift = {pv_q[14:0], in_byte_i[5:0]};
    need2    = 1'b0;
    v        = '0;
    sum      = '0;
    r0_o     = '0;
    r1_o     = '0;
    num_o    = 2'd0;

    if (!err_q) begin
      if (br_q == 2'd0) begin
        if (!in_byte_i[7]) begin
          cp   = {13'b0, in_byte_i};
          done = 1'b1;
        end else if (in_byte_i >= u2u_pkg::LEAD2_MIN && in_byte_i <= u2u_pkg::LEAD2_MAX) begin
          pv_d = {16'b0, in_byte_i[4:0]};
          br_d = 2'd1;
          sl_d = u2u_pkg::SEQ_TWO;
        end else if (in_byte_i >= u2u_pkg::LEAD3_MIN && in_byte_i <= u2u_pkg::LEAD3_MAX) begin
          pv_d = {17'b0, in_byte_i[3:0]};
          br_d = 2'd2;
          sl_d = u2u_pkg::SEQ_THREE;
        end else if (in_byte_i >= u2u_pkg::LEAD4_MIN && in_byte_i <= u2u_pkg::LEAD4_MAX) begin
          pv_d = {18'b0, in_byte_i[2:0]};
          br_d = 2'd3;
          sl_d = u2u_pkg::SEQ_FOUR;
        end else begin
          raise = 1'b1;
        end
      end else if ((in_byte_i & u2u_pkg::CONT_MASK) != u2u_pkg::CONT_TAG) begin
        raise = 1'b1;
      end else begin
        pv_d = pv_shift;
        br_d = br_q - 2'd1;
        if (br_q == 2'd1) begin
          cp   = pv_shift;
          done = 1'b1;
          pv_d = '0;
          sl_d = u2u_pkg::SEQ_NONE;
          unique case (sl_q)
            u2u_pkg::SEQ_TWO:   minimum = u2u_pkg::MIN_TWO;
            u2u_pkg::SEQ_THREE: minimum = u2u_pkg::MIN_THREE;
            default:            minimum = u2u_pkg::SUPP_BASE;
          endcase
        end
      end

      // completed code point: range check, capacity check, emit
      if (done) begin
        need2 = (cp >= u2u_pkg::SUPP_BASE);
        v     = cp - u2u_pkg::SUPP_BASE;
        sum   = {1'b0, cnt_q} + (need2 ? 17'd2 : 17'd1);
        if (cp < minimum || (cp >= u2u_pkg::SURR_LO && cp <= u2u_pkg::SURR_HI) ||
            cp > u2u_pkg::CP_MAX) begin
          raise = 1'b1;
        end else if (sum > {2'b0, capacity_i}) begin
          raise = 1'b1;
        end else if (!need2) begin
          r0_o.code_unit  = cp[15:0];
          r0_o.unit_valid = 1'b1;
          num_o           = 2'd1;
          cnt_d           = sum[15:0];
        end else begin
          r0_o.code_unit  = u2u_pkg::HI_SURR_BASE + {6'b0, v[19:10]};
          r0_o.unit_valid = 1'b1;
          r1_o.code_unit  = u2u_pkg::LO_SURR_BASE + {6'b0, v[9:0]};
          r1_o.unit_valid = 1'b1;
          num_o           = 2'd2;
          cnt_d           = sum[15:0];
        end
      end

      // sequence cut off by the end mark
      if (eos_i && br_d != 2'd0) begin
        raise = 1'b1;
      end

      if (raise) begin
        err_d = 1'b1;
        pv_d  = '0;
        br_d  = 2'd0;
        sl_d  = u2u_pkg::SEQ_NONE;
      end
    end

    // end of string: tag final result, then clear string state
    if (eos_i) begin
      if (num_o == 2'd2) begin
        r1_o.last        = 1'b1;
        r1_o.error       = err_d;
        r1_o.total_units = cnt_d;
      end else begin
        num_o            = 2'd1;
        r0_o.last        = 1'b1;
        r0_o.error       = err_d;
        r0_o.total_units = cnt_d;
      end
      pv_d  = '0;
      br_d  = 2'd0;
      sl_d  = u2u_pkg::SEQ_NONE;
      err_d = 1'b0;
      cnt_d = '0;
    end
  end

  // string state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      br_q  <= 2'd0;
      sl_q  <= u2u_pkg::SEQ_NONE;
      err_q <= 1'b0;
      cnt_q <= '0;
    end else if (go_i) begin
      pv_q  <= pv_d;
      br_q  <= br_d;
      sl_q  <= sl_d;
      err_q <= err_d;
      cnt_q <= cnt_d;
    end
  end

  assign status_o.sticky_err = err_q;
  assign status_o.bytes_rem  = br_q;
  assign status_o.unit_cnt   = cnt_q;

endmodule

/* src/u2u_outq.sv */
module u2u_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_num_i,
  input  u2u_pkg::result_t  r0_i,
  input  u2u_pkg::result_t  r1_i,
  output logic [2:0]        level_o,
  u2u_out_if.source         out_o
);

  u2u_pkg::result_t mem_q [u2u_pkg::OUTQ_DEPTH];
  logic [1:0] wr_ptr_q;
  logic [1:0] rd_ptr_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] wr_next;

  assign pop     = out_o.valid && out_o.ready;
  assign wr_next = wr_ptr_q + 2'd1;

  // result storage, up to two items written per cycle
  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= r0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_next] <= r1_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_num_i;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push_num_i} - {2'b0, pop};
    end
  end

  assign level_o           = cnt_q;
  assign out_o.valid       = (cnt_q != 3'd0);
  assign out_o.code_unit   = mem_q[rd_ptr_q].code_unit;
  assign out_o.unit_valid  = mem_q[rd_ptr_q].unit_valid;
  assign out_o.last        = mem_q[rd_ptr_q].last;
  assign out_o.error       = mem_q[rd_ptr_q].error;
  assign out_o.total_units = mem_q[rd_ptr_q].total_units;

endmodule

/* src/utf8_to_utf16_transcoder.sv */
// UTF-8 to UTF-16 transcoder
// in_i carries one UTF-8 byte per item with an end_of_string mark on the
// final byte of each string. out_o carries UTF-16 code units, one per item;
// the final item of a string has last set and carries the error flag and
// the unit count. A string that ends without a unit gives one bare item.
// cfg_i writes capacity_units, the most units a string may produce; write
// it only while the block is idle. cfg_i is always ready.
// Throughput: one byte per cycle while the output queue has room; a byte that
// yields a surrogate pair puts two items on out_o, which then drains at one item per cycle while out_o is ready.
// A byte's first unit reaches out_o by way of the input register, then the
// decode into the output queue; the byte waits in the input register while
// the output queue lacks room for its items.
// Reset clears all string state and sets capacity_units to 32767.
// When the receiver stalls, the four-entry output queue fills and in_i
// ready drops once fewer than two free entries remain; nothing is lost.
`include "assert_macros.svh"

module utf8_to_utf16_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2u_in_if.sink     in_i,
  u2u_cfg_if.sink    cfg_i,
  u2u_out_if.source  out_o
);

  logic        stage_vld_q;
  logic [7:0]  byte_q;
  logic        eos_q;
  logic [14:0] capacity_q;
  logic        advance;
  logic        in_fire;
  logic [2:0]  outq_level;
  logic [1:0]  dec_num;
  logic        seq_closed_ok;
  logic        str_cleared;

  u2u_pkg::result_t     dec_r0;
  u2u_pkg::result_t     dec_r1;
  u2u_pkg::dec_status_t dec_status;

  // capacity register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= u2u_pkg::CAP_RESET;
    end else if (cfg_i.valid) begin
      capacity_q <= cfg_i.capacity_units;
    end
  end

  // input register
  assign advance    = stage_vld_q && (outq_level <= 3'd2);
  assign in_i.ready = !stage_vld_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else if (in_fire) begin
      stage_vld_q <= 1'b1;
    end else if (advance) begin
      stage_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_i.in_byte;
      eos_q  <= in_i.end_of_string;
    end
  end

  // byte decode and string state
  u2u_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (advance),
    .in_byte_i  (byte_q),
    .eos_i      (eos_q),
    .capacity_i (capacity_q),
    .num_o      (dec_num),
    .r0_o       (dec_r0),
    .r1_o       (dec_r1),
    .status_o   (dec_status)
  );

  // output queue
  u2u_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (advance ? dec_num : 2'd0),
    .r0_i       (dec_r0),
    .r1_i       (dec_r1),
    .level_o    (outq_level),
    .out_o      (out_o)
  );

  // checks
  assign seq_closed_ok = !dec_status.sticky_err || dec_status.bytes_rem == 2'd0;
  assign str_cleared   = dec_status.unit_cnt == 16'd0 && !dec_status.sticky_err;

  `ASSERT_AT_CLK(a_outq_bound, outq_level <= 3'd4, "output queue overflow")
  `ASSERT_AT_CLK(a_err_no_open_seq, seq_closed_ok, "sequence open after error")
  `ASSERT_NEXT(a_eos_clears, advance && eos_q, str_cleared, "string state kept past end")

endmodule

/* test/u2u_checker.sv */
module u2u_checker (
  input  logic clk_i,
  input  logic rst_ni,
  u2u_in_if    in_i,
  u2u_cfg_if   cfg_i,
  u2u_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   strings_o,
  output int   bad_strings_o
);

  // decoder state mirrored from the accepted bytes
  logic [14:0] capacity;
  logic [20:0] partial_cp;
  logic [1:0]  conts_left;
  logic [1:0]  seq_len;
  logic        string_bad;
  logic [15:0] units_so_far;

  // utf-16 items still owed by the block, oldest first
  u2u_pkg::result_t expected_units[$];
  u2u_pkg::result_t want;

  task automatic mark_bad();
    string_bad = 1'b1;
    partial_cp = '0;
    conts_left = 2'd0;
    seq_len    = u2u_pkg::SEQ_NONE;
  endtask

  task automatic clear_string();
    partial_cp   = '0;
    conts_left   = 2'd0;
    seq_len      = u2u_pkg::SEQ_NONE;
    string_bad   = 1'b0;
    units_so_far = '0;
  endtask

  function automatic u2u_pkg::result_t unit_item(logic [15:0] unit, logic has_unit);
    u2u_pkg::result_t r;
    r            = '0;
    r.code_unit  = unit;
    r.unit_valid = has_unit;
    return r;
  endfunction

  // decode one utf-8 byte and queue the utf-16 items it yields
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    u2u_pkg::result_t made[$];
    u2u_pkg::result_t tail;
    logic        done;
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [20:0] offset;
    int          need;
    done     = 1'b0;
    cp       = '0;
    floor_cp = '0;
    if (!string_bad) begin
      if (conts_left == 2'd0) begin
        // lead byte
        if (!b[7]) begin
          cp   = {13'd0, b};
          done = 1'b1;
        end else if (b >= u2u_pkg::LEAD2_MIN && b <= u2u_pkg::LEAD2_MAX) begin
          partial_cp = {16'd0, b[4:0]};
          conts_left = 2'd1;
          seq_len    = u2u_pkg::SEQ_TWO;
        end else if (b >= u2u_pkg::LEAD3_MIN && b <= u2u_pkg::LEAD3_MAX) begin
          partial_cp = {17'd0, b[3:0]};
          conts_left = 2'd2;
          seq_len    = u2u_pkg::SEQ_THREE;
        end else if (b >= u2u_pkg::LEAD4_MIN && b <= u2u_pkg::LEAD4_MAX) begin
          partial_cp = {18'd0, b[2:0]};
          conts_left = 2'd3;
          seq_len    = u2u_pkg::SEQ_FOUR;
        end else begin
          mark_bad();
        end
      end else if ((b & u2u_pkg::CONT_MASK) != u2u_pkg::CONT_TAG) begin
        mark_bad();
      end else begin
        // continuation byte
        partial_cp = {partial_cp[14:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          cp = partial_cp;
          case (seq_len)
            u2u_pkg::SEQ_TWO:   floor_cp = u2u_pkg::MIN_TWO;
            u2u_pkg::SEQ_THREE: floor_cp = u2u_pkg::MIN_THREE;
            default:            floor_cp = u2u_pkg::SUPP_BASE;
          endcase
          done       = 1'b1;
          partial_cp = '0;
          seq_len    = u2u_pkg::SEQ_NONE;
        end
      end

      // range, surrogate and capacity checks on a finished code point
      if (done) begin
        need = (cp < u2u_pkg::SUPP_BASE) ? 1 : 2;
        if (cp < floor_cp || (cp >= u2u_pkg::SURR_LO && cp <= u2u_pkg::SURR_HI) ||
            cp > u2u_pkg::CP_MAX) begin
          mark_bad();
        end else if (int'(units_so_far) + need > int'(capacity)) begin
          mark_bad();
        end else if (need == 1) begin
          made.push_back(unit_item(cp[15:0], 1'b1));
          units_so_far = units_so_far + 16'd1;
        end else begin
          offset = cp - u2u_pkg::SUPP_BASE;
          made.push_back(unit_item(u2u_pkg::HI_SURR_BASE + {6'd0, offset[19:10]}, 1'b1));
          made.push_back(unit_item(u2u_pkg::LO_SURR_BASE + {6'd0, offset[9:0]}, 1'b1));
          units_so_far = units_so_far + 16'd2;
        end
      end

      // string cut off inside a sequence
      if (eos && conts_left != 2'd0) mark_bad();
    end

    // end mark rides on the last item, or on a bare one
    if (eos) begin
      if (made.size() == 0) made.push_back(unit_item('0, 1'b0));
      tail             = made.pop_back();
      tail.last        = 1'b1;
      tail.error       = string_bad;
      tail.total_units = units_so_far;
      made.push_back(tail);
      clear_string();
    end
    foreach (made[i]) expected_units.push_back(made[i]);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // watch the three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = u2u_pkg::CAP_RESET;
      clear_string();
      expected_units.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      strings_o     = 0;
      bad_strings_o = 0;
    end else begin
      // capacity write
      if (cfg_i.valid && cfg_i.ready) capacity = cfg_i.capacity_units;

      // result item against the oldest expectation
      if (res_i.valid && res_i.ready) begin
        if (res_i.last) begin
          strings_o++;
          if (res_i.error) bad_strings_o++;
        end
        if (expected_units.size() == 0) begin
          $error("unexpected result item: code_unit 0x%0h last %0b",
                 res_i.code_unit, res_i.last);
          fail_count_o++;
        end else begin
          want = expected_units.pop_front();
          compare_field("code_unit", want.code_unit, res_i.code_unit);
          compare_field("unit_valid", {15'd0, want.unit_valid}, {15'd0, res_i.unit_valid});
          compare_field("last", {15'd0, want.last}, {15'd0, res_i.last});
          compare_field("error", {15'd0, want.error}, {15'd0, res_i.error});
          compare_field("total_units", want.total_units, res_i.total_units);
        end
      end

      // accepted byte
      if (in_i.valid && in_i.ready) decode_byte(in_i.in_byte, in_i.end_of_string);
      pending_o = expected_units.size();
    end
  end

endmodule

/* test/testbench.sv */
module testbench;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int NUM_PHASES       = 8;

  // ways to break a utf-8 string
  typedef enum int {
    FAULT_LEAD,
    FAULT_OVERLONG,
    FAULT_SURROGATE,
    FAULT_TOO_BIG,
    FAULT_CONT,
    FAULT_TRUNC
  } fault_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int   fail_count;
  int   pending;
  int   strings_seen;
  int   bad_strings;
  int   cycle_count    = 0;
  int   items_sent     = 0;
  int   strings_sent   = 0;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  bit   hold_output    = 1'b0;

  logic [7:0] utf8_bytes[$];

  u2u_in_if  in_ch ();
  u2u_cfg_if cfg_ch ();
  u2u_out_if out_ch ();

  utf8_to_utf16_transcoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  u2u_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_ch),
    .cfg_i         (cfg_ch),
    .res_i         (out_ch),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .strings_o     (strings_seen),
    .bad_strings_o (bad_strings)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_to_utf16_transcoder verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_output = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         = 1'b1;
    in_ch.in_byte       = b;
    in_ch.end_of_string = eos;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string();
    foreach (utf8_bytes[i]) send_byte(utf8_bytes[i], i == utf8_bytes.size() - 1);
    strings_sent++;
    utf8_bytes.delete();
  endtask

  // wait until every expected item has come and the pipeline is quiet
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [14:0] cap);
    cfg_ch.valid          = 1'b1;
    cfg_ch.capacity_units = cap;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // raw utf-8 encoding of a value in a given length, no checks
  task automatic add_seq(input logic [20:0] v, input int len);
    case (len)
      1: utf8_bytes.push_back({1'b0, v[6:0]});
      2: begin
        utf8_bytes.push_back({3'b110, v[10:6]});
        utf8_bytes.push_back({2'b10, v[5:0]});
      end
      3: begin
        utf8_bytes.push_back({4'b1110, v[15:12]});
        utf8_bytes.push_back({2'b10, v[11:6]});
        utf8_bytes.push_back({2'b10, v[5:0]});
      end
      default: begin
        utf8_bytes.push_back({5'b11110, v[20:18]});
        utf8_bytes.push_back({2'b10, v[17:12]});
        utf8_bytes.push_back({2'b10, v[11:6]});
        utf8_bytes.push_back({2'b10, v[5:0]});
      end
    endcase
  endtask

  // one well-formed code point of random length
  task automatic add_point();
    int          pick;
    logic [20:0] v;
    int          len;
    pick = $urandom_range(99);
    if (pick < 35) begin
      v   = 21'($urandom_range(0, 8'h7F));
      len = 1;
    end else if (pick < 55) begin
      v   = 21'($urandom_range(8'h80, 11'h7FF));
      len = 2;
    end else if (pick < 80) begin
      v   = $urandom_range(0, 1) ? 21'($urandom_range(12'h800, 16'hD7FF))
                                 : 21'($urandom_range(16'hE000, 16'hFFFF));
      len = 3;
    end else begin
      v   = 21'($urandom_range(17'h10000, 21'h10FFFF));
      len = 4;
    end
    add_seq(v, len);
  endtask

  // one malformed piece; cut says the string must end here
  task automatic add_fault(input fault_e kind, output bit cut);
    int         len;
    int         pos;
    logic [7:0] junk;
    cut = 1'b0;
    case (kind)
      FAULT_LEAD: begin
        utf8_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                                  : 8'($urandom_range(8'hF5, 8'hFF)));
      end
      FAULT_OVERLONG: begin
        case ($urandom_range(2))
          0: add_seq(21'($urandom_range(0, 8'h7F)), 2);
          1: add_seq(21'($urandom_range(0, 11'h7FF)), 3);
          default: add_seq(21'($urandom_range(0, 16'hFFFF)), 4);
        endcase
      end
      FAULT_SURROGATE: add_seq(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
      FAULT_TOO_BIG: add_seq(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      FAULT_CONT: begin
        len = $urandom_range(2, 4);
        add_seq(21'($urandom), len);
        pos = utf8_bytes.size() - $urandom_range(1, len - 1);
        do junk = 8'($urandom_range(255));
        while ((junk & u2u_pkg::CONT_MASK) == u2u_pkg::CONT_TAG);
        utf8_bytes[pos] = junk;
      end
      default: begin
        len = $urandom_range(2, 4);
        add_seq(21'($urandom), len);
        repeat ($urandom_range(1, len - 1)) void'(utf8_bytes.pop_back());
        cut = 1'b1;
      end
    endcase
  endtask

  // mostly valid strings, some with one fault, a few of pure noise
  task automatic random_string();
    int points;
    int bad_at;
    bit cut;
    cut    = 1'b0;
    points = ($urandom_range(99) < 10) ? $urandom_range(8, 30) : $urandom_range(1, 6);
    if ($urandom_range(99) < 5) begin
      repeat (points) utf8_bytes.push_back(8'($urandom_range(255)));
    end else begin
      bad_at = ($urandom_range(99) < 25) ? $urandom_range(0, points - 1) : -1;
      for (int i = 0; i < points && !cut; i++) begin
        if (i == bad_at) add_fault(fault_e'($urandom_range(0, 5)), cut);
        else add_point();
      end
    end
    send_string();
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
      default: begin src_idle_pct = 19; sink_stall_pct = 19; end
    endcase
  endtask

  initial begin
    logic [14:0] capacity_plan[NUM_PHASES];
    int          target;
    bit          paused;
    in_ch.valid           = 1'b0;
    in_ch.in_byte         = '0;
    in_ch.end_of_string   = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.capacity_units = '0;
    capacity_plan = '{u2u_pkg::CAP_RESET, 15'd0, 15'd5, 15'd1,
                      15'($urandom_range(8, 40)), 15'd2, 15'd3, u2u_pkg::CAP_RESET};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // boundary code points of each length, then one of each kind of error
    utf8_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                   8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    // bad lead byte
    utf8_bytes = '{8'h80};
    send_string();
    // overlong three-byte form
    utf8_bytes = '{8'hE0, 8'h80, 8'h80};
    send_string();
    // encoded surrogate
    utf8_bytes = '{8'hED, 8'hA0, 8'h80};
    send_string();
    // above the last code point
    utf8_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_string();
    // bad continuation, rest of the string dropped
    utf8_bytes = '{8'hC2, 8'h41, 8'h7A};
    send_string();
    // cut off inside a sequence
    utf8_bytes = '{8'hE2, 8'h82};
    send_string();
    settle();

    // random phases over capacities and idling patterns
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) write_capacity(capacity_plan[phase]);
      set_idling(phase % 4);
      if (phase == 0) hold_output = 1'b1;
      target = items_sent + RANDOM_PER_PHASE;
      paused = 1'b0;
      while (items_sent < target) begin
        random_string();
        // sender waits for the output to run dry once, midway through phase 5
        if (phase == 5 && !paused && items_sent > target - RANDOM_PER_PHASE / 2) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    $display("sent %0d bytes in %0d strings under %0d capacity settings and four idle patterns",
             items_sent, strings_sent, NUM_PHASES);
    $display("checked %0d string ends, %0d of them reported invalid or over capacity",
             strings_seen, bad_strings);
    if (fail_count == 0) begin
      $display("utf8_to_utf16_transcoder verification clean");
    end else begin
      $display("utf8_to_utf16_transcoder verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/u2u_pkg.sv
src/u2u_in_if.sv
src/u2u_out_if.sv
src/u2u_cfg_if.sv
src/u2u_decode.sv
src/u2u_outq.sv
src/utf8_to_utf16_transcoder.sv
test/u2u_checker.sv
test/testbench.sv
